FILE: rtl/ssrg_pkg.sv
// Shared types, constants and period table builders for the stepper sigmoid ramp generator.
package ssrg_pkg;

    localparam int RETRACT_TABLE_DEPTH = 128;
    localparam int EXTEND_TABLE_DEPTH  = 512;
    localparam int TIMER_CLOCK_HZ      = 108000000;

    localparam int RETRACT_AW = $clog2(RETRACT_TABLE_DEPTH);
    localparam int EXTEND_AW  = $clog2(EXTEND_TABLE_DEPTH);

    localparam int STEP_W   = 16;
    localparam int POS_W    = 32;
    localparam int PERIOD_W = 16;
    localparam int CFG_W    = 9;

    // Command codes of the input word.
    localparam logic [1:0] CMD_TICK          = 2'd0;
    localparam logic [1:0] CMD_START_RETRACT = 2'd1;
    localparam logic [1:0] CMD_START_EXTEND  = 2'd2;

    // Finish codes reported in motion_state.
    localparam logic [1:0] FINISH_RETRACT = 2'd0;
    localparam logic [1:0] FINISH_EXTEND  = 2'd1;
    localparam logic [1:0] FINISH_NONE    = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HOME_DEBOUNCE = 2'd0;
    localparam logic [1:0] CFG_STEP_LIMIT    = 2'd1;
    localparam logic [1:0] CFG_PULSES        = 2'd2;

    localparam logic [7:0] DEBOUNCE_RESET = 8'd6;
    localparam logic [8:0] LIMIT_RESET    = 9'd318;
    localparam logic [7:0] PULSES_RESET   = 8'd8;

    // Fixed-point curve constants (frequencies in milli-Hz, exponentials in Q30).
    localparam logic [63:0] EXP_NEG_TENTH_Q30 = 64'd971561780;
    localparam logic [63:0] ONE_Q30           = 64'd1 << 30;
    localparam logic [63:0] HALF_Q30          = 64'd1 << 29;
    localparam logic [63:0] NUM_SCALED        = (64'(TIMER_CLOCK_HZ) * 64'd1000) << 24;
    localparam int          EXTEND_HALF       = 159;

    localparam logic [63:0] RETRACT_FMIN = 64'd2000000;
    localparam logic [63:0] RETRACT_SPAN = 64'd5714286;
    localparam logic [63:0] ACCEL_FMIN   = 64'd2500000;
    localparam logic [63:0] ACCEL_SPAN   = 64'd1700000;
    localparam logic [63:0] DECEL_FMIN   = 64'd2000000;
    localparam logic [63:0] DECEL_SPAN   = 64'd2200000;

    typedef struct packed {
        logic [1:0] cmd;
        logic       home_sensor_on;
    } req_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] period_counts;
        logic [7:0]          repeat_count;
        logic [PERIOD_W-1:0] compare_value;
        logic                load_strobe;
        logic                stop_strobe;
        logic [1:0]          motion_state;
        logic [POS_W-1:0]    position_now;
    } rsp_t;

    typedef struct packed {
        logic [7:0] home_debounce_ticks;
        logic [8:0] extend_step_limit;
        logic [7:0] pulses_per_update;
    } cfg_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] retract_period;
        logic [PERIOD_W-1:0] extend_period;
    } rom_rd_t;

    typedef logic [PERIOD_W-1:0] period_t;
    typedef period_t retract_rom_t [RETRACT_TABLE_DEPTH];
    typedef period_t extend_rom_t [EXTEND_TABLE_DEPTH];

    // The functions below only build the constant period tables at elaboration.
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // r^n in Q30 by square and multiply, each product rounded half up.
    function automatic logic [63:0] pow_r_q30(input logic [15:0] n);
        logic [63:0] acc;
        logic [63:0] base;
        acc  = ONE_Q30;
        base = EXP_NEG_TENTH_Q30;
        for (int k = 0; k < 16; k++)
        begin
            if (n[k])
                acc = (acc * base + HALF_Q30) >> 30;
            base = (base * base + HALF_Q30) >> 30;
        end
        return acc;
    endfunction

    function automatic logic [63:0] sigmoid_q24(input int xt);
        logic [63:0] p;
        if (xt <= 0)
        begin
            p = pow_r_q30(16'(-xt));
            return div_u64(64'd1 << 54, ONE_Q30 + p);
        end
        p = pow_r_q30(16'(xt));
        return div_u64(p << 24, ONE_Q30 + p);
    endfunction

    function automatic period_t period_from(input logic [63:0] fmin, input logic [63:0] span,
                                            input int xt);
        logic [63:0] freq;
        logic [63:0] q;
        freq = (fmin << 24) + span * sigmoid_q24(xt);
        q    = div_u64(NUM_SCALED, freq);
        return (q > 64'd65535) ? 16'hFFFF : q[15:0];
    endfunction

    function automatic retract_rom_t build_retract_rom();
        retract_rom_t rom;
        for (int i = 0; i < RETRACT_TABLE_DEPTH; i++)
            rom[i] = period_from(RETRACT_FMIN, RETRACT_SPAN, 60 - 3 * i);
        return rom;
    endfunction

    function automatic extend_rom_t build_extend_rom();
        extend_rom_t rom;
        for (int i = 0; i < EXTEND_TABLE_DEPTH; i++)
        begin
            if (i < EXTEND_HALF)
                rom[i] = period_from(ACCEL_FMIN, ACCEL_SPAN, 60 - 2 * i);
            else
                rom[i] = period_from(DECEL_FMIN, DECEL_SPAN, 6 * (i - EXTEND_HALF) - 800);
        end
        return rom;
    endfunction

endpackage

FILE: rtl/stepper_sigmoid_ramp_generator.sv
// Top level of the stepper sigmoid ramp generator: configuration, control, ROMs, output register.
// A result word is registered and valid in the cycle after its request word is accepted.
// One word per cycle while the output is taken; the period ROMs are read ahead at the next step count.
// The output register frees the input side whenever it is empty or being taken.
// Reset is asynchronous, active low: moving outward, idle, step count zero, position all ones,
// not finished, and the registers at debounce 6, step limit 318 and 8 pulses per update.
module stepper_sigmoid_ramp_generator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  ssrg_pkg::req_t             req,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output ssrg_pkg::rsp_t             rsp,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [ssrg_pkg::CFG_W-1:0] cfg_data
);

    ssrg_pkg::cfg_t              cfg_reg;
    ssrg_pkg::rom_rd_t           rom_rd;
    ssrg_pkg::rsp_t              rsp_next;
    ssrg_pkg::rsp_t              rsp_reg;
    logic                        rsp_valid_reg;
    logic                        accept;
    logic [ssrg_pkg::STEP_W-1:0] step_addr;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign cfg_ready = 1'b1;

    ssrg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req       (req),
        .cfg       (cfg_reg),
        .rom_rd    (rom_rd),
        .step_addr (step_addr),
        .rsp_next  (rsp_next)
    );

    ssrg_period_rom u_rom (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_addr (step_addr),
        .rd        (rom_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.home_debounce_ticks <= ssrg_pkg::DEBOUNCE_RESET;
            cfg_reg.extend_step_limit   <= ssrg_pkg::LIMIT_RESET;
            cfg_reg.pulses_per_update   <= ssrg_pkg::PULSES_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ssrg_pkg::CFG_HOME_DEBOUNCE: cfg_reg.home_debounce_ticks <= cfg_data[7:0];
                ssrg_pkg::CFG_STEP_LIMIT:    cfg_reg.extend_step_limit   <= cfg_data;
                ssrg_pkg::CFG_PULSES:        cfg_reg.pulses_per_update   <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (req_ready)
            rsp_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: rtl/ssrg_period_rom.sv
// Retract and extend period ROMs with registered read data, addressed by the step count.
module ssrg_period_rom (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ssrg_pkg::STEP_W-1:0] step_addr,
    output ssrg_pkg::rom_rd_t           rd
);

    localparam ssrg_pkg::retract_rom_t RETRACT_ROM = ssrg_pkg::build_retract_rom();
    localparam ssrg_pkg::extend_rom_t  EXTEND_ROM  = ssrg_pkg::build_extend_rom();

    logic [ssrg_pkg::RETRACT_AW-1:0] ret_idx;
    logic [ssrg_pkg::EXTEND_AW-1:0]  ext_idx;
    ssrg_pkg::rom_rd_t               rd_reg;

    // Step counts past the end of a table stay on its last entry.
    assign ret_idx = (step_addr >= ssrg_pkg::STEP_W'(ssrg_pkg::RETRACT_TABLE_DEPTH))
                   ? ssrg_pkg::RETRACT_AW'(ssrg_pkg::RETRACT_TABLE_DEPTH - 1)
                   : step_addr[ssrg_pkg::RETRACT_AW-1:0];
    assign ext_idx = (step_addr >= ssrg_pkg::STEP_W'(ssrg_pkg::EXTEND_TABLE_DEPTH))
                   ? ssrg_pkg::EXTEND_AW'(ssrg_pkg::EXTEND_TABLE_DEPTH - 1)
                   : step_addr[ssrg_pkg::EXTEND_AW-1:0];

    // Reset loads the entries for step zero, which is the step count after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg.retract_period <= RETRACT_ROM[0];
            rd_reg.extend_period  <= EXTEND_ROM[0];
        end
        else
        begin
            rd_reg.retract_period <= RETRACT_ROM[ret_idx];
            rd_reg.extend_period  <= EXTEND_ROM[ext_idx];
        end
    end

    assign rd = rd_reg;

endmodule

FILE: rtl/ssrg_ctrl.sv
// Move state registers and the per-word update that forms each result word.
module ssrg_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  ssrg_pkg::req_t              req,
    input  ssrg_pkg::cfg_t              cfg,
    input  ssrg_pkg::rom_rd_t           rom_rd,
    output logic [ssrg_pkg::STEP_W-1:0] step_addr,
    output ssrg_pkg::rsp_t              rsp_next
);

    logic                         outward_reg;
    logic                         outward_next;
    logic                         running_reg;
    logic                         running_next;
    logic [ssrg_pkg::STEP_W-1:0]  step_reg;
    logic [ssrg_pkg::STEP_W-1:0]  step_next;
    logic [7:0]                   off_run_reg;
    logic [7:0]                   off_run_next;
    logic [ssrg_pkg::POS_W-1:0]   pos_reg;
    logic [ssrg_pkg::POS_W-1:0]   pos_next;
    logic [1:0]                   finish_reg;
    logic [1:0]                   finish_next;

    logic [7:0]                   off_inc;
    logic [ssrg_pkg::STEP_W-1:0]  step_inc;
    logic [ssrg_pkg::PERIOD_W-1:0] period;
    logic [ssrg_pkg::PERIOD_W:0]  period_plus;

    assign off_inc     = (off_run_reg == 8'hFF) ? 8'hFF : off_run_reg + 8'd1;
    assign step_inc    = (step_reg == '1) ? step_reg : step_reg + ssrg_pkg::STEP_W'(1);
    assign period      = outward_reg ? rom_rd.extend_period : rom_rd.retract_period;
    assign period_plus = {1'b0, period} + (ssrg_pkg::PERIOD_W + 1)'(1);

    always_comb
    begin
        outward_next = outward_reg;
        running_next = running_reg;
        step_next    = step_reg;
        off_run_next = off_run_reg;
        pos_next     = pos_reg;
        finish_next  = finish_reg;
        rsp_next     = '0;

        if (accept)
        begin
            unique case (req.cmd) inside
                ssrg_pkg::CMD_START_RETRACT, ssrg_pkg::CMD_START_EXTEND:
                begin
                    outward_next = (req.cmd == ssrg_pkg::CMD_START_EXTEND);
                    running_next = 1'b1;
                    step_next    = '0;
                    pos_next     = '1;
                    finish_next  = ssrg_pkg::FINISH_NONE;
                end
                ssrg_pkg::CMD_TICK:
                begin
                    if (running_reg && !outward_reg)
                    begin
                        off_run_next = req.home_sensor_on ? 8'd0 : off_inc;
                        if (off_run_next >= cfg.home_debounce_ticks)
                        begin
                            running_next         = 1'b0;
                            finish_next          = ssrg_pkg::FINISH_RETRACT;
                            rsp_next.stop_strobe = 1'b1;
                        end
                        else
                        begin
                            rsp_next.load_strobe = 1'b1;
                            pos_next  = pos_reg - ssrg_pkg::POS_W'(cfg.pulses_per_update);
                            step_next = step_inc;
                        end
                    end
                    else if (running_reg)
                    begin
                        if (step_reg > ssrg_pkg::STEP_W'(cfg.extend_step_limit))
                        begin
                            running_next         = 1'b0;
                            finish_next          = ssrg_pkg::FINISH_EXTEND;
                            rsp_next.stop_strobe = 1'b1;
                        end
                        else
                        begin
                            rsp_next.load_strobe = 1'b1;
                            // A sensor-off tick while extending pins the position at zero.
                            if (req.home_sensor_on)
                            begin
                                pos_next  = pos_reg + ssrg_pkg::POS_W'(cfg.pulses_per_update);
                                step_next = step_inc;
                            end
                            else
                            begin
                                pos_next = '0;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (rsp_next.load_strobe)
        begin
            rsp_next.period_counts = period;
            rsp_next.repeat_count  = cfg.pulses_per_update;
            rsp_next.compare_value = period_plus[ssrg_pkg::PERIOD_W:1];
        end
        rsp_next.motion_state = finish_next;
        rsp_next.position_now = pos_next;
    end

    // The ROM is read at the step count the next word will see, so its data is ready in time.
    assign step_addr = step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outward_reg <= 1'b1;
            running_reg <= 1'b0;
            step_reg    <= '0;
            off_run_reg <= '0;
            pos_reg     <= '1;
            finish_reg  <= ssrg_pkg::FINISH_NONE;
        end
        else
        begin
            outward_reg <= outward_next;
            running_reg <= running_next;
            step_reg    <= step_next;
            off_run_reg <= off_run_next;
            pos_reg     <= pos_next;
            finish_reg  <= finish_next;
        end
    end

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the stepper sigmoid ramp generator.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssrg_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int IDLE_PCT    = 14;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 4;

    // e^-0.1 in Q30, and the 108 MHz timer clock in milli-Hz scaled by 2^24.
    localparam longint unsigned DECAY_Q30    = 64'd971561780;
    localparam longint unsigned UNIT_Q30     = 64'd1 << 30;
    localparam longint unsigned ROUND_Q30    = 64'd1 << 29;
    localparam longint unsigned TICKS_SCALED = 64'd108000000000 << 24;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    req_t       req       = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    rsp_t       rsp;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = CFG_HOME_DEBOUNCE;
    logic [8:0] cfg_data  = '0;

    bit   steady = 1'b0;
    req_t script[$];
    cfg_t plan;

    class ramp_tracker;
        cfg_t      regs;
        bit        outward;
        bit        moving;
        bit [15:0] steps;
        bit [7:0]  off_run;
        bit [31:0] pos;
        bit [1:0]  done_code;
        rsp_t      awaited[$];
        int        errors;

        function new();
            regs.home_debounce_ticks = DEBOUNCE_RESET;
            regs.extend_step_limit   = LIMIT_RESET;
            regs.pulses_per_update   = PULSES_RESET;
            outward   = 1'b1;
            moving    = 1'b0;
            steps     = '0;
            off_run   = '0;
            pos       = '1;
            done_code = FINISH_NONE;
            errors    = 0;
        endfunction

        function longint unsigned decay_q30(int unsigned n);
            longint unsigned acc;
            longint unsigned sq;
            acc = UNIT_Q30;
            sq  = DECAY_Q30;
            while (n != 0)
            begin
                if (n[0])
                    acc = (acc * sq + ROUND_Q30) >> 30;
                sq = (sq * sq + ROUND_Q30) >> 30;
                n  = n >> 1;
            end
            return acc;
        endfunction

        // Logistic 1/(1+e^(xt/10)) in Q24, xt in tenths.
        function longint unsigned logistic_q24(int xt);
            longint unsigned p;
            if (xt <= 0)
            begin
                p = decay_q30(-xt);
                return (64'd1 << 54) / (UNIT_Q30 + p);
            end
            p = decay_q30(xt);
            return (p << 24) / (UNIT_Q30 + p);
        endfunction

        function bit [15:0] reload_for(longint unsigned fmin, longint unsigned span, int xt);
            longint unsigned freq;
            longint unsigned q;
            freq = (fmin << 24) + span * logistic_q24(xt);
            q    = TICKS_SCALED / freq;
            return (q > 64'd65535) ? 16'hFFFF : q[15:0];
        endfunction

        function bit [15:0] inward_reload(bit [15:0] s);
            int i;
            i = (s < RETRACT_TABLE_DEPTH) ? int'(s) : RETRACT_TABLE_DEPTH - 1;
            return reload_for(64'd2000000, 64'd5714286, 60 - 3 * i);
        endfunction

        function bit [15:0] outward_reload(bit [15:0] s);
            int i;
            i = (s < EXTEND_TABLE_DEPTH) ? int'(s) : EXTEND_TABLE_DEPTH - 1;
            if (i < EXTEND_HALF)
                return reload_for(64'd2500000, 64'd1700000, 60 - 2 * i);
            return reload_for(64'd2000000, 64'd2200000, 6 * (i - EXTEND_HALF) - 800);
        endfunction

        function void write_register(logic [1:0] idx, logic [8:0] data);
            case (idx)
                CFG_HOME_DEBOUNCE: regs.home_debounce_ticks = data[7:0];
                CFG_STEP_LIMIT:    regs.extend_step_limit   = data;
                CFG_PULSES:        regs.pulses_per_update   = data[7:0];
                default: ;
            endcase
        endfunction

        function void note_command(req_t w);
            rsp_t      r;
            bit [15:0] per;
            bit        loaded;
            r      = '0;
            per    = '0;
            loaded = 1'b0;
            if (w.cmd == CMD_START_RETRACT || w.cmd == CMD_START_EXTEND)
            begin
                outward   = (w.cmd == CMD_START_EXTEND);
                moving    = 1'b1;
                steps     = '0;
                pos       = '1;
                done_code = FINISH_NONE;
            end
            else if (w.cmd == CMD_TICK && moving)
            begin
                if (!outward)
                begin
                    // The off run survives across moves; only a sensor-on tick clears it.
                    if (!w.home_sensor_on)
                    begin
                        if (off_run != 8'hFF)
                            off_run++;
                    end
                    else
                        off_run = '0;
                    if (off_run >= regs.home_debounce_ticks)
                    begin
                        moving        = 1'b0;
                        done_code     = FINISH_RETRACT;
                        r.stop_strobe = 1'b1;
                    end
                    else
                    begin
                        per    = inward_reload(steps);
                        loaded = 1'b1;
                        pos    = pos - 32'(regs.pulses_per_update);
                        if (steps != 16'hFFFF)
                            steps++;
                    end
                end
                else
                begin
                    if (steps > 16'(regs.extend_step_limit))
                    begin
                        moving        = 1'b0;
                        done_code     = FINISH_EXTEND;
                        r.stop_strobe = 1'b1;
                    end
                    else
                    begin
                        per    = outward_reload(steps);
                        loaded = 1'b1;
                        if (w.home_sensor_on)
                        begin
                            pos = pos + 32'(regs.pulses_per_update);
                            if (steps != 16'hFFFF)
                                steps++;
                        end
                        else
                            pos = '0;
                    end
                end
            end
            if (loaded)
            begin
                r.period_counts = per;
                r.repeat_count  = regs.pulses_per_update;
                r.compare_value = 16'(({1'b0, per} + 17'd1) >> 1);
                r.load_strobe   = 1'b1;
            end
            r.motion_state = done_code;
            r.position_now = pos;
            awaited.push_back(r);
        endfunction

        function void field_match(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_burst(rsp_t got);
            rsp_t want;
            if (awaited.size() == 0)
            begin
                $error("result word arrived with no command outstanding");
                errors++;
                return;
            end
            want = awaited.pop_front();
            field_match("period_counts", 32'(want.period_counts), 32'(got.period_counts));
            field_match("repeat_count", 32'(want.repeat_count), 32'(got.repeat_count));
            field_match("compare_value", 32'(want.compare_value), 32'(got.compare_value));
            field_match("load_strobe", 32'(want.load_strobe), 32'(got.load_strobe));
            field_match("stop_strobe", 32'(want.stop_strobe), 32'(got.stop_strobe));
            field_match("motion_state", 32'(want.motion_state), 32'(got.motion_state));
            field_match("position_now", want.position_now, got.position_now);
        endfunction
    endclass

    ramp_tracker tracker = new();

    stepper_sigmoid_ramp_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
            tracker.check_burst(rsp);
        rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic void add_word(logic [1:0] cmd, logic sensor);
        req_t w;
        w.cmd            = cmd;
        w.home_sensor_on = sensor;
        script.push_back(w);
    endfunction

    function automatic void plan_retract(int on_ticks);
        int dip_max;
        dip_max = (plan.home_debounce_ticks > 6) ? 6 : int'(plan.home_debounce_ticks) - 1;
        add_word(CMD_START_RETRACT, 1'($urandom_range(1)));
        for (int k = 0; k < on_ticks; k++)
        begin
            // Short sensor-off dips that stay under the debounce run.
            if (dip_max > 0 && $urandom_range(99) < 8)
                repeat ($urandom_range(1, dip_max)) add_word(CMD_TICK, 1'b0);
            add_word(CMD_TICK, 1'b1);
        end
        if ($urandom_range(99) < 15)
            return;
        repeat (plan.home_debounce_ticks) add_word(CMD_TICK, 1'b0);
        repeat ($urandom_range(0, 2)) add_word(CMD_TICK, 1'($urandom_range(1)));
    endfunction

    function automatic void plan_extend(bit may_abort);
        int pushes;
        add_word(CMD_START_EXTEND, 1'($urandom_range(1)));
        pushes = int'(plan.extend_step_limit) + 2;
        if (may_abort && $urandom_range(99) < 15)
            pushes = int'($urandom_range(0, pushes));
        while (pushes > 0)
        begin
            if ($urandom_range(99) < 6)
                add_word(CMD_TICK, 1'b0);
            else
            begin
                add_word(CMD_TICK, 1'b1);
                pushes--;
            end
        end
        repeat ($urandom_range(0, 2)) add_word(CMD_TICK, 1'($urandom_range(1)));
    endfunction

    function automatic void plan_phase(int budget);
        int pick;
        while (script.size() < budget)
        begin
            pick = int'($urandom_range(99));
            if (pick < 40)
                plan_retract(int'($urandom_range(0, 24)));
            else if (pick < 80)
                plan_extend(1'b1);
            else
                repeat ($urandom_range(1, 4))
                    add_word(2'($urandom_range(3)), 1'($urandom_range(1)));
        end
    endfunction

    task automatic drain();
        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_word(input req_t w);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        do
            @(posedge clk);
        while (!req_ready);
        tracker.note_command(w);
    endtask

    task automatic send_script(input bit pause_midway);
        int half;
        half = script.size() / 2;
        foreach (script[i])
        begin
            if (pause_midway && i == half)
            begin
                // Hold the input side until every word in flight has come back.
                req_valid <= 1'b0;
                drain();
            end
            send_word(script[i]);
        end
        req_valid <= 1'b0;
        script.delete();
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [8:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.write_register(idx, data);
    endtask

    task automatic configure(input cfg_t s, input bit poke_unused);
        write_cfg(CFG_HOME_DEBOUNCE, {1'b0, s.home_debounce_ticks});
        write_cfg(CFG_STEP_LIMIT, s.extend_step_limit);
        write_cfg(CFG_PULSES, {1'b0, s.pulses_per_update});
        if (poke_unused)
            write_cfg(CFG_UNUSED, 9'($urandom_range(511)));
        cfg_valid <= 1'b0;
        plan = s;
        @(posedge clk);
    endtask

    initial
    begin
        cfg_t setting;
        int   budget;
        plan.home_debounce_ticks = DEBOUNCE_RESET;
        plan.extend_step_limit   = LIMIT_RESET;
        plan.pulses_per_update   = PULSES_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset configuration.
        add_word(CMD_TICK, 1'b1);
        add_word(CMD_UNUSED, 1'b0);
        add_word(CMD_START_RETRACT, 1'b1);
        add_word(CMD_TICK, 1'b1);
        add_word(CMD_TICK, 1'b1);
        add_word(CMD_TICK, 1'b0);
        add_word(CMD_TICK, 1'b0);
        add_word(CMD_TICK, 1'b1);
        repeat (6) add_word(CMD_TICK, 1'b0);
        add_word(CMD_TICK, 1'b1);
        add_word(CMD_START_EXTEND, 1'b0);
        add_word(CMD_TICK, 1'b0);
        repeat (3) add_word(CMD_TICK, 1'b1);
        add_word(CMD_UNUSED, 1'b1);
        // Restart while running; the carried-over off run ends this retract at once.
        add_word(CMD_START_RETRACT, 1'b0);
        add_word(CMD_TICK, 1'b0);
        add_word(CMD_START_EXTEND, 1'b1);
        add_word(CMD_TICK, 1'b1);
        send_script(1'b0);
        drain();

        for (int ph = 1; ph <= 5; ph++)
        begin
            case (ph)
                1:
                begin
                    setting = {DEBOUNCE_RESET, LIMIT_RESET, PULSES_RESET};
                    budget  = 200;
                end
                2:
                begin
                    setting = {8'd1, 9'd1, 8'd1};
                    budget  = 200;
                end
                3:
                begin
                    setting = {8'd255, 9'd511, 8'd255};
                    budget  = 900;
                end
                4:
                begin
                    setting = {8'd0, 9'd40, 8'd200};
                    budget  = 150;
                end
                default:
                begin
                    setting.home_debounce_ticks = 8'($urandom_range(1, 12));
                    setting.extend_step_limit   = 9'($urandom_range(1, 60));
                    setting.pulses_per_update   = 8'($urandom_range(1, 255));
                    budget = 150;
                end
            endcase
            configure(setting, ph == 5);
            if (ph == 3)
            begin
                // Run the extend table up to its last entry and the retract table past its last entry.
                plan_extend(1'b0);
                plan_retract(140);
            end
            steady = (ph == 2);
            plan_phase(budget);
            send_script(ph == 1);
            drain();
        end

        if (tracker.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
